// ===== rtl/wsc_pkg.sv =====
// shared types and constants of the window step temperature controller
package wsc_pkg;

    localparam int TEMP_W     = 12;
    localparam int DIFF_W     = TEMP_W + 1;
    localparam int SET_W      = 10;
    localparam int FINE_TH_W  = 8;
    localparam int THRESH_W   = 10;
    localparam int PCT_W      = 7;
    localparam int TICK_W     = 32;
    localparam int MODE_W     = 3;
    localparam int DIR_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [PCT_W-1:0] PCT_FULL       = PCT_W'(100);
    localparam logic [PCT_W-1:0] PCT_CLOSED     = PCT_W'(0);
    localparam logic [PCT_W-1:0] START_POSITION = PCT_W'(10);

    localparam logic [SET_W-1:0]     SET_TEMP_RST      = SET_W'(400);
    localparam logic [FINE_TH_W-1:0] FINE_TH_RST       = FINE_TH_W'(8);
    localparam logic [THRESH_W-1:0]  COARSE_TH_RST     = THRESH_W'(32);
    localparam logic [PCT_W-1:0]     FINE_STEP_RST     = PCT_W'(5);
    localparam logic [PCT_W-1:0]     COARSE_STEP_RST   = PCT_W'(20);
    localparam logic [TICK_W-1:0]    REFRESH_TICKS_RST = TICK_W'(1000 * 60 * 15);
    localparam logic [TICK_W-1:0]    WARMUP_TICKS_RST  = TICK_W'(1000 * 60 * 30);

    localparam logic [MODE_W-1:0] MODE_COARSE  = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_FINE    = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_REFRESH = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_WARMUP  = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_TICK    = MODE_W'(4);

    localparam logic [CFG_IDX_W-1:0] CFG_SET_TEMP      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FINE_TH       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COARSE_TH     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_FINE_STEP     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_COARSE_STEP   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_TICKS = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_TICKS  = CFG_IDX_W'(6);

    typedef enum logic [DIR_W-1:0] {
        DIR_NONE  = 2'd0,
        DIR_OPEN  = 2'd1,
        DIR_CLOSE = 2'd2
    } t_dir;

    typedef struct packed {
        logic [PCT_W-1:0] position;
        t_dir             dir;
    } t_move;

endpackage

// ===== rtl/wsc_in_if.sv =====
// input item channel: valid, ready and temperature reading payload
interface wsc_in_if;
    logic                         valid;
    logic                         ready;
    logic [wsc_pkg::MODE_W-1:0]   mode;
    logic signed [wsc_pkg::TEMP_W-1:0] inside_temp;
    logic signed [wsc_pkg::TEMP_W-1:0] outside_temp;

    modport source (output valid, mode, inside_temp, outside_temp, input ready);
    modport sink   (input valid, mode, inside_temp, outside_temp, output ready);
endinterface

// ===== rtl/wsc_out_if.sv =====
// result item channel: valid, ready and window command payload
interface wsc_out_if;
    logic                              valid;
    logic                              ready;
    logic [wsc_pkg::PCT_W-1:0]         window_percent;
    logic [wsc_pkg::DIR_W-1:0]         direction;
    logic                              override_active;
    logic signed [wsc_pkg::TEMP_W-1:0] last_inside_temp;
    logic signed [wsc_pkg::TEMP_W-1:0] last_outside_temp;

    modport source (output valid, window_percent, direction, override_active,
                    last_inside_temp, last_outside_temp, input ready);
    modport sink   (input valid, window_percent, direction, override_active,
                    last_inside_temp, last_outside_temp, output ready);
endinterface

// ===== rtl/wsc_deadband.sv =====
// deadband compare and saturating window step
module wsc_deadband (
    input  logic signed [wsc_pkg::TEMP_W-1:0]   i_inside,
    input  logic        [wsc_pkg::SET_W-1:0]    i_set_temp,
    input  logic        [wsc_pkg::THRESH_W-1:0] i_threshold,
    input  logic        [wsc_pkg::PCT_W-1:0]    i_step,
    input  logic        [wsc_pkg::PCT_W-1:0]    i_position,
    output wsc_pkg::t_move                      o_move
);
    import wsc_pkg::*;

    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] neg_diff;
    logic                     warmer;
    logic [TEMP_W-1:0]        mag;
    logic [PCT_W:0]           sum;

    assign diff     = $signed({i_inside[TEMP_W-1], i_inside})
                    - $signed({{(DIFF_W-SET_W){1'b0}}, i_set_temp});
    assign neg_diff = -diff;
    assign warmer   = !diff[DIFF_W-1] && (diff != '0);
    assign mag      = warmer ? diff[TEMP_W-1:0] : neg_diff[TEMP_W-1:0];
    assign sum      = {1'b0, i_position} + {1'b0, i_step};

    always_comb begin
        o_move.position = i_position;
        o_move.dir      = DIR_NONE;
        if (mag > {{(TEMP_W-THRESH_W){1'b0}}, i_threshold}) begin
            if (warmer) begin
                o_move.dir      = DIR_OPEN;
                o_move.position = (sum > {1'b0, PCT_FULL}) ? PCT_FULL : sum[PCT_W-1:0];
            end else begin
                o_move.dir      = DIR_CLOSE;
                o_move.position = (i_position < i_step) ? PCT_CLOSED : i_position - i_step;
            end
        end
    end
endmodule

// ===== rtl/window_step_temp_controller.sv =====
// window step temperature controller top level
//
//  channel  dir  handshake      payload
//  i_in     in   valid/ready    mode, inside_temp, outside_temp
//  o_out    out  valid/ready    window_percent, direction, override_active,
//                               last_inside_temp, last_outside_temp
//  i_cfg    in   write enable   i_cfg_idx, i_cfg_data
//
// one item per cycle when o_out is not stalled: an input register feeds the
// step logic, whose result and new state are taken in the result register.
// the input register refills while the result waits; a stalled result holds
// both stages. synchronous reset restores the defaults and an empty pipe.
module window_step_temp_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    wsc_in_if.sink                           i_in,
    wsc_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [wsc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wsc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import wsc_pkg::*;

    // configuration
    logic [SET_W-1:0]     r_set_temp;
    logic [FINE_TH_W-1:0] r_fine_th;
    logic [THRESH_W-1:0]  r_coarse_th;
    logic [PCT_W-1:0]     r_fine_step;
    logic [PCT_W-1:0]     r_coarse_step;
    logic [TICK_W-1:0]    r_refresh_ticks;
    logic [TICK_W-1:0]    r_warmup_ticks;

    // input stage
    logic                     r_in_valid;
    logic [MODE_W-1:0]        r_in_mode;
    logic signed [TEMP_W-1:0] r_in_inside;
    logic signed [TEMP_W-1:0] r_in_outside;

    // controller state
    logic [PCT_W-1:0]         r_position,     n_position;
    logic [PCT_W-1:0]         r_saved,        n_saved;
    logic                     r_enabled,      n_enabled;
    logic                     r_skip_fine,    n_skip_fine;
    logic [TICK_W-1:0]        r_ticks_left,   n_ticks_left;
    logic signed [TEMP_W-1:0] r_inside_seen,  n_inside_seen;
    logic signed [TEMP_W-1:0] r_outside_seen, n_outside_seen;
    t_dir                     n_dir;

    // result stage
    logic                     r_out_valid;
    logic [PCT_W-1:0]         r_out_pct;
    t_dir                     r_out_dir;
    logic                     r_out_override;
    logic signed [TEMP_W-1:0] r_out_inside;
    logic signed [TEMP_W-1:0] r_out_outside;

    logic                advance;
    logic                coarse;
    logic [THRESH_W-1:0] mv_threshold;
    logic [PCT_W-1:0]    mv_step;
    t_move               mv;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign coarse       = (r_in_mode == MODE_COARSE);
    assign mv_threshold = coarse ? r_coarse_th : {{(THRESH_W-FINE_TH_W){1'b0}}, r_fine_th};
    assign mv_step      = coarse ? r_coarse_step : r_fine_step;

    wsc_deadband u_deadband (
        .i_inside    (r_in_inside),
        .i_set_temp  (r_set_temp),
        .i_threshold (mv_threshold),
        .i_step      (mv_step),
        .i_position  (r_position),
        .o_move      (mv)
    );

    always_comb begin
        n_position     = r_position;
        n_saved        = r_saved;
        n_enabled      = r_enabled;
        n_skip_fine    = r_skip_fine;
        n_ticks_left   = r_ticks_left;
        n_inside_seen  = r_inside_seen;
        n_outside_seen = r_outside_seen;
        n_dir          = DIR_NONE;
        case (r_in_mode)
            MODE_COARSE: begin
                n_inside_seen  = r_in_inside;
                n_outside_seen = r_in_outside;
                if (r_enabled) begin
                    n_position = mv.position;
                    n_dir      = mv.dir;
                    if (mv.dir != DIR_NONE) begin
                        n_skip_fine = 1'b1;
                    end
                end
            end
            MODE_FINE: begin
                if (r_enabled) begin
                    if (r_skip_fine) begin
                        n_skip_fine = 1'b0;
                    end else begin
                        n_position = mv.position;
                        n_dir      = mv.dir;
                    end
                end
            end
            MODE_REFRESH: begin
                if (r_enabled) begin
                    n_saved      = r_position;
                    n_enabled    = 1'b0;
                    n_ticks_left = r_refresh_ticks;
                    n_position   = PCT_FULL;
                end
            end
            MODE_WARMUP: begin
                if (r_enabled) begin
                    n_saved      = r_position;
                    n_enabled    = 1'b0;
                    n_ticks_left = r_warmup_ticks;
                    n_position   = PCT_CLOSED;
                end
            end
            MODE_TICK: begin
                if (!r_enabled) begin
                    if (r_ticks_left <= TICK_W'(1)) begin
                        n_ticks_left = '0;
                        n_position   = r_saved;
                        n_enabled    = 1'b1;
                    end else begin
                        n_ticks_left = r_ticks_left - TICK_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_temp      <= SET_TEMP_RST;
            r_fine_th       <= FINE_TH_RST;
            r_coarse_th     <= COARSE_TH_RST;
            r_fine_step     <= FINE_STEP_RST;
            r_coarse_step   <= COARSE_STEP_RST;
            r_refresh_ticks <= REFRESH_TICKS_RST;
            r_warmup_ticks  <= WARMUP_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SET_TEMP:      r_set_temp      <= i_cfg_data[SET_W-1:0];
                CFG_FINE_TH:       r_fine_th       <= i_cfg_data[FINE_TH_W-1:0];
                CFG_COARSE_TH:     r_coarse_th     <= i_cfg_data[THRESH_W-1:0];
                CFG_FINE_STEP:     r_fine_step     <= i_cfg_data[PCT_W-1:0];
                CFG_COARSE_STEP:   r_coarse_step   <= i_cfg_data[PCT_W-1:0];
                CFG_REFRESH_TICKS: r_refresh_ticks <= i_cfg_data[TICK_W-1:0];
                CFG_WARMUP_TICKS:  r_warmup_ticks  <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_mode    <= i_in.mode;
            r_in_inside  <= i_in.inside_temp;
            r_in_outside <= i_in.outside_temp;
        end
    end

    // state and result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position     <= START_POSITION;
            r_saved        <= PCT_CLOSED;
            r_enabled      <= 1'b1;
            r_skip_fine    <= 1'b0;
            r_ticks_left   <= '0;
            r_inside_seen  <= '0;
            r_outside_seen <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (advance) begin
                r_position     <= n_position;
                r_saved        <= n_saved;
                r_enabled      <= n_enabled;
                r_skip_fine    <= n_skip_fine;
                r_ticks_left   <= n_ticks_left;
                r_inside_seen  <= n_inside_seen;
                r_outside_seen <= n_outside_seen;
                r_out_valid    <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_pct      <= n_position;
            r_out_dir      <= n_dir;
            r_out_override <= !n_enabled;
            r_out_inside   <= n_inside_seen;
            r_out_outside  <= n_outside_seen;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.window_percent    = r_out_pct;
    assign o_out.direction         = r_out_dir;
    assign o_out.override_active   = r_out_override;
    assign o_out.last_inside_temp  = r_out_inside;
    assign o_out.last_outside_temp = r_out_outside;
endmodule
